FILE: hdl/bls_pkg.sv
// -----------------------------------------------------------------------------
// Bounded LIFO stack package
// Request and response types and status codes shared by the core and checker.
// -----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    ModePush   = 2'd0,
    ModePop    = 2'd1,
    ModeSearch = 2'd2,
    ModeShow   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StatusPopped    = 3'd0,
    StatusPopEmpty  = 3'd1,
    StatusFound     = 3'd2,
    StatusNotFound  = 3'd3,
    StatusShown     = 3'd4,
    StatusShowEmpty = 3'd5,
    StatusPushFull  = 3'd6
  } status_e;

  localparam logic signed [WordW-1:0] DataNegOne = -32'sd1;
  localparam logic signed [WordW-1:0] DataZero   = 32'sd0;

  typedef struct packed {
    mode_e                    mode;
    logic signed [WordW-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WordW-1:0]  data;
    logic                     last;
  } rsp_t;

endpackage

FILE: hdl/bounded_lifo_stack_search_core.sv
// -----------------------------------------------------------------------------
// Bounded LIFO stack core
// Stack of signed 32-bit words with push, pop, search and show requests.
// -----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results come out one
// per cycle on rsp_o, each marked by a one-cycle strobe_o; the receiver cannot
// hold them off, so every result must be captured the cycle it appears. The
// words sit in a single-port-write, registered-read memory, so a word that is
// read passes through rd_data_q before it can reach a result. Per request:
//   push          busy never rises; a full stack gives one result in the
//                 next cycle
//   pop           one memory read, then the result; a direct result when empty
//   search        entries are read bottom-up until the first match or the
//                 top entry, then one result; a direct result if empty
//   show          one result per cycle from top to bottom, last
//                 set on the bottom entry; a single result if empty
// Any result with last set is shown while busy is already low, so the next
// request may be taken in that same cycle. Entries above the fill count never
// reach a result, so the memory needs no clearing after reset.
// -----------------------------------------------------------------------------
module bounded_lifo_stack_search_core #(
  parameter int unsigned DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bls_pkg::req_t  req_i,
  output logic           strobe_o,
  output bls_pkg::rsp_t  rsp_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StPop,
    StSearch,
    StShow
  } state_e;

  state_e                          state_q;
  logic [CntW-1:0]                 count_q;
  logic [AddrW-1:0]                idx_q;
  logic signed [bls_pkg::WordW-1:0] key_q;
  logic                            strobe_q;
  bls_pkg::rsp_t                   rsp_q;

  // stack storage
  logic signed [bls_pkg::WordW-1:0] mem [DEPTH];
  logic signed [bls_pkg::WordW-1:0] rd_data_q;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CntW-1:0]  top_cnt;
  logic [AddrW-1:0] top_addr;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;

  assign accept   = start && (state_q == StIdle);
  assign full     = (count_q == CntW'(DEPTH));
  assign empty    = (count_q == '0);
  assign top_cnt  = count_q - 1'b1;
  assign top_addr = top_cnt[AddrW-1:0];
  assign wr_en    = accept && (req_i.mode == bls_pkg::ModePush) && !full;

  // Read address for the word needed next cycle. Writes only happen while
  // idle, and every read follows its request's acceptance, so a read never
  // meets a write to the same entry in one edge.
  always_comb begin
    case (state_q)
      StIdle: begin
        rd_addr = (req_i.mode == bls_pkg::ModeSearch) ? '0 : top_addr;
      end
      StSearch: begin
        rd_addr = idx_q + 1'b1;
      end
      StShow: begin
        rd_addr = idx_q - 1'b1;
      end
      default: begin
        rd_addr = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AddrW-1:0]] <= req_i.value;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Control and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      idx_q    <= '0;
      key_q    <= '0;
      strobe_q <= 1'b0;
      rsp_q    <= '0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (req_i.mode)
              bls_pkg::ModePush: begin
                if (full) begin
                  strobe_q <= 1'b1;
                  rsp_q    <= '{status: bls_pkg::StatusPushFull,
                                data: bls_pkg::DataZero, last: 1'b1};
                end else begin
                  count_q <= count_q + 1'b1;
                end
              end
              bls_pkg::ModePop: begin
                if (empty) begin
                  strobe_q <= 1'b1;
                  rsp_q    <= '{status: bls_pkg::StatusPopEmpty,
                                data: bls_pkg::DataNegOne, last: 1'b1};
                end else begin
                  count_q <= top_cnt;
                  state_q <= StPop;
                end
              end
              bls_pkg::ModeSearch: begin
                if (empty) begin
                  strobe_q <= 1'b1;
                  rsp_q    <= '{status: bls_pkg::StatusNotFound,
                                data: bls_pkg::DataZero, last: 1'b1};
                end else begin
                  idx_q   <= '0;
                  key_q   <= req_i.value;
                  state_q <= StSearch;
                end
              end
              default: begin
                if (empty) begin
                  strobe_q <= 1'b1;
                  rsp_q    <= '{status: bls_pkg::StatusShowEmpty,
                                data: bls_pkg::DataZero, last: 1'b1};
                end else begin
                  idx_q   <= top_addr;
                  state_q <= StShow;
                end
              end
            endcase
          end
        end
        StPop: begin
          strobe_q <= 1'b1;
          rsp_q    <= '{status: bls_pkg::StatusPopped, data: rd_data_q, last: 1'b1};
          state_q  <= StIdle;
        end
        StSearch: begin
          // rd_data_q holds entry idx_q; scan bottom-up, stop on first hit
          if (rd_data_q == key_q) begin
            strobe_q <= 1'b1;
            rsp_q    <= '{status: bls_pkg::StatusFound,
                          data: bls_pkg::DataZero, last: 1'b1};
            state_q  <= StIdle;
          end else if (idx_q == top_addr) begin
            strobe_q <= 1'b1;
            rsp_q    <= '{status: bls_pkg::StatusNotFound,
                          data: bls_pkg::DataZero, last: 1'b1};
            state_q  <= StIdle;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StShow: begin
          // top-down walk, bottom entry closes the request
          strobe_q <= 1'b1;
          rsp_q    <= '{status: bls_pkg::StatusShown, data: rd_data_q,
                        last: (idx_q == '0)};
          if (idx_q == '0) begin
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy     = (state_q != StIdle);
  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

endmodule

FILE: hdl/bls_checker.sv
// -----------------------------------------------------------------------------
// Bounded LIFO stack checker
// Port-level properties of the stack core, attached by bind.
// -----------------------------------------------------------------------------
module bls_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input bls_pkg::req_t req_i,
  input logic          strobe_o,
  input bls_pkg::rsp_t rsp_o
);

  // push never occupies the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.mode == bls_pkg::ModePush) |=> !busy)
    else $error("push request left core busy");

  // pop either answers empty at once or goes busy for the read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.mode == bls_pkg::ModePop) |=>
      busy || (strobe_o && rsp_o.status == bls_pkg::StatusPopEmpty &&
               rsp_o.data == bls_pkg::DataNegOne && rsp_o.last))
    else $error("pop request gave neither read nor empty result");

  // the closing result of a request appears with the core free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && rsp_o.last |-> !busy)
    else $error("last result while still busy");

  // only a show walk produces results that are not last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !rsp_o.last |-> rsp_o.status == bls_pkg::StatusShown && busy)
    else $error("non-final result outside a show walk");

  // a shown entry that is not last is followed by another one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !rsp_o.last |=> strobe_o && rsp_o.status == bls_pkg::StatusShown)
    else $error("show walk interrupted");

endmodule

bind bounded_lifo_stack_search_core bls_checker u_bls_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .req_i   (req_i),
  .strobe_o(strobe_o),
  .rsp_o   (rsp_o)
);
